### hdl/xrr_pkg.sv
// Package: constants, state type and helpers for the ranged xoshiro256++ source.
package xrr_pkg;

   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = 4;
   localparam int CNT_W     = $clog2(WORD_W);

   // xoshiro256++ rotate and shift amounts
   localparam int ROT_OUT   = 23;
   localparam int SHL_T     = 17;
   localparam int ROT_W3    = 45;

   // Fixed words loaded after the seed
   localparam logic [WORD_W-1:0] INIT_W1 = WORD_W'(1);
   localparam logic [WORD_W-1:0] INIT_W2 = WORD_W'(2);
   localparam logic [WORD_W-1:0] INIT_W3 = WORD_W'(3);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   function automatic word_type rotl64(input word_type x, input int k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

endpackage

### hdl/xoshiro256pp_ranged_random.sv
// Top level: xoshiro256++ generator with bit-serial modulo range reduction.
// A request runs 64 remainder steps (ST_DIV), then the add in ST_DONE; when the span
//    wraps to zero the steps are skipped. A new request is taken only back in ST_IDLE,
//    after the one-bit-per-cycle restoring remainder loop; a result may wait in the output
//    register, and ST_DONE holds while the earlier result is still pending.
// Reset (synchronous, active high) loads the generator with 0,1,2,3 and idles.
module xoshiro256pp_ranged_random
   import xrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [WORD_W-1:0] req_range_lower,
   input  logic [WORD_W-1:0] req_range_upper,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_value
);

   state_type state_ff, state_in;

   word_type gen_ff [NUM_WORDS];
   word_type gen_in [NUM_WORDS];

   word_type          rem_ff, rem_in;
   word_type          dvd_ff, dvd_in;
   word_type          span_ff, span_in;
   word_type          lower_ff, lower_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   word_type          rsp_value_ff, rsp_value_in;

   logic      accept;
   logic      finish;
   logic      div_last;
   word_type  raw;
   word_type  tmp_t;
   word_type  req_span;
   logic      span_zero;
   logic [WORD_W:0] trial;
   logic [WORD_W:0] diff;
   logic      ge;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = span_zero ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      div_last  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV:  div_last  = (cnt_ff == CNT_LAST);
         ST_DONE: finish    = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   // Generator step
   always_comb begin
      raw   = rotl64(gen_ff[0] + gen_ff[3], ROT_OUT) + gen_ff[0];
      tmp_t = gen_ff[1] << SHL_T;
      gen_in[2] = gen_ff[2] ^ gen_ff[0];
      gen_in[3] = gen_ff[3] ^ gen_ff[1];
      gen_in[1] = gen_ff[1] ^ gen_in[2];
      gen_in[0] = gen_ff[0] ^ gen_in[3];
      gen_in[2] = gen_in[2] ^ tmp_t;
      gen_in[3] = rotl64(gen_in[3], ROT_W3);
   end

   assign req_span  = req_range_upper - req_range_lower + WORD_W'(1);
   assign span_zero = (req_span == '0);

   // One remainder bit per cycle, dividend enters MSB first
   assign trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, span_ff};
   assign ge    = (trial >= {1'b0, span_ff});

   always_comb begin
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      span_in      = span_ff;
      lower_in     = lower_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         span_in  = req_span;
         lower_in = req_range_lower;
         dvd_in   = raw;
         cnt_in   = '0;
         // full-width span: skip the reduction, raw goes straight to the add
         rem_in   = span_zero ? raw : '0;
      end else if (state_ff == ST_DIV) begin
         rem_in = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rem_ff + lower_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gen_ff[0]    <= '0;
         gen_ff[1]    <= INIT_W1;
         gen_ff[2]    <= INIT_W2;
         gen_ff[3]    <= INIT_W3;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            gen_ff[0] <= csr_wdata;
            gen_ff[1] <= INIT_W1;
            gen_ff[2] <= INIT_W2;
            gen_ff[3] <= INIT_W3;
         end else if (accept) begin
            gen_ff <= gen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      span_ff      <= span_in;
      lower_ff     <= lower_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request transaction did not start work");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < span_ff))
      else $error("partial remainder not below span");

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !div_last) |=> (state_ff == ST_DIV))
      else $error("remainder loop ended early");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result overwrote a pending response");

   a_seed_reload: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (gen_ff[1] == INIT_W1 && gen_ff[2] == INIT_W2 && gen_ff[3] == INIT_W3))
      else $error("seed write did not reload generator words");
`endif

endmodule

### tb/xoshiro256pp_ranged_random_test.sv
// Self-checking testbench for the ranged xoshiro256++ random source.
`timescale 1ns / 1ps

module xoshiro256pp_ranged_random_test;
   import xrr_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 240;
   localparam int DRAIN_CYCLES  = 80;
   localparam int MAX_PRINTS    = 100;

   typedef struct packed {
      word_type lower;
      word_type upper;
   } range_request_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_we = 1'b0;
   word_type csr_wdata = '0;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_range_lower = '0;
   word_type req_range_upper = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_value;

   range_request_type pending_requests[$];
   word_type          expected_values[$];
   word_type          gen_word[NUM_WORDS];

   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;

   xoshiro256pp_ranged_random uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_range_lower (req_range_lower),
      .req_range_upper (req_range_upper),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------- generator model ----------------

   function automatic word_type rot_left(word_type x, int unsigned k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

   function automatic void load_generator(word_type s);
      gen_word[0] = s;
      gen_word[1] = INIT_W1;
      gen_word[2] = INIT_W2;
      gen_word[3] = INIT_W3;
   endfunction

   function automatic word_type advance_generator();
      word_type raw;
      word_type t;
      raw = rot_left(gen_word[0] + gen_word[3], ROT_OUT) + gen_word[0];
      t   = gen_word[1] << SHL_T;
      gen_word[2] = gen_word[2] ^ gen_word[0];
      gen_word[3] = gen_word[3] ^ gen_word[1];
      gen_word[1] = gen_word[1] ^ gen_word[2];
      gen_word[0] = gen_word[0] ^ gen_word[3];
      gen_word[2] = gen_word[2] ^ t;
      gen_word[3] = rot_left(gen_word[3], ROT_W3);
      return raw;
   endfunction

   function automatic word_type ranged_value(word_type lower, word_type upper);
      word_type span;
      word_type raw;
      span = upper - lower + WORD_W'(1);
      raw  = advance_generator();
      // span wrapped to zero: full 64-bit range, no reduction
      if (span == '0)
         return raw + lower;
      return (raw % span) + lower;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic word_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic range_request_type random_request();
      range_request_type r;
      word_type span;
      int unsigned pick;
      pick    = $urandom_range(0, 99);
      r.lower = ($urandom_range(0, 3) == 0) ? WORD_W'($urandom_range(0, 255)) : rand_word();
      if (pick < 35) begin
         r.upper = rand_word();
      end else if (pick < 55) begin
         r.upper = r.lower + WORD_W'($urandom_range(0, 1000));
      end else if (pick < 70) begin
         span    = WORD_W'(1) << $urandom_range(1, 63);
         r.upper = r.lower + span - WORD_W'(1);
      end else if (pick < 80) begin
         span    = rand_word() >> $urandom_range(0, 63);
         r.upper = r.lower + span - WORD_W'(1);
      end else if (pick < 88) begin
         r.upper = r.lower - WORD_W'(1);
      end else if (pick < 94) begin
         r.upper = r.lower;
      end else begin
         r.upper = r.lower - WORD_W'($urandom_range(1, 1000));
      end
      return r;
   endfunction

   function automatic void add_request(word_type lower, word_type upper);
      range_request_type r;
      r.lower = lower;
      r.upper = upper;
      pending_requests.push_back(r);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // polls on the falling edge so all clocked updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_values.size() != 0);
   endtask

   task automatic write_seed(word_type s);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= s;
      @(posedge clock);
      csr_we    <= 1'b0;
      load_generator(s);
      @(negedge clock);
   endtask

   // ---------------- request driver ----------------

   always @(posedge clock) begin : drive_proc
      range_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_values.push_back(ranged_value(req_range_lower, req_range_upper));
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            nxt = pending_requests.pop_front();
            req_valid       <= 1'b1;
            req_range_lower <= nxt.lower;
            req_range_upper <= nxt.upper;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: gap_left = 0;
                  4, 5, 6, 7: gap_left = $urandom_range(1, 20);
                  default:    gap_left = $urandom_range(21, 90);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- result monitor ----------------

   always @(posedge clock) begin : monitor_proc
      word_type want;
      logic     nxt_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction value=%h", rsp_value));
            end else begin
               want = expected_values.pop_front();
               if (rsp_value !== want)
                  report_mismatch($sformatf("value got %h want %h", rsp_value, want));
            end
         end
         // stall pattern cycles through four modes, switching on cycle_count
         case ((cycle_count / 700) % 4)
            0: nxt_ready = 1'b1;
            1: nxt_ready = 1'($urandom_range(0, 1));
            2: nxt_ready = ($urandom_range(0, 7) == 0);
            default: begin
               if (stall_left != 0) begin
                  stall_left--;
                  nxt_ready = 1'b0;
               end else begin
                  stall_left = $urandom_range(0, 25);
                  nxt_ready  = 1'b1;
               end
            end
         endcase
         rsp_ready <= nxt_ready;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      word_type seeds[6];
      word_type all_ones;
      word_type msb;
      all_ones = '1;
      msb      = WORD_W'(1) << (WORD_W - 1);
      seeds[0] = all_ones;
      seeds[1] = WORD_W'(1);
      seeds[2] = msb;
      seeds[3] = rand_word();
      seeds[4] = rand_word();
      seeds[5] = '0;

      load_generator('0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: runs from the reset state
      add_request('0, all_ones);                 // full span, raw output
      add_request(all_ones, all_ones);           // single-value range
      add_request('0, '0);
      add_request(WORD_W'(1), '0);               // full span, lower 1
      add_request(all_ones, all_ones - WORD_W'(1)); // full span, lower all-ones
      add_request(msb, msb - WORD_W'(1));
      add_request(WORD_W'(5), WORD_W'(2));       // inverted range
      add_request(all_ones, '0);                 // wraps to span 2
      add_request('0, WORD_W'(1));
      add_request('0, msb);
      add_request('0, msb - WORD_W'(1));
      add_request(msb, all_ones);
      add_request(WORD_W'(1), all_ones);         // span all-ones
      add_request('0, 64'hAAAA_AAAA_AAAA_AAAA);
      add_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      add_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      add_request('0, WORD_W'(6));
      add_request('0, WORD_W'(9));
      add_request(WORD_W'(100), WORD_W'(199));
      add_request(64'h0000_0001_0000_0000, 64'h0000_0001_FFFF_FFFF);
      add_request(msb - WORD_W'(1), msb);

      // each seed write happens with nothing in flight
      foreach (seeds[i]) begin
         wait_drained();
         write_seed(seeds[i]);
         for (int n = 0; n < RANDOM_ITEMS; n++)
            pending_requests.push_back(random_request());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
hdl/xrr_pkg.sv
hdl/xoshiro256pp_ranged_random.sv
tb/xoshiro256pp_ranged_random_test.sv
